// ===== rtl/core/smd_pkg.sv =====
// Shared types, constants and helpers for the stream message deframer.
// No dependencies; used by smd_frame, smd_outq and stream_message_deframer_core.
package smd_pkg;

  localparam int BYTE_W         = 8;
  localparam int CFG_W          = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int LEN_W          = 32;
  localparam int HDR_CNT_W      = 4;
  localparam int OUT_OFFSET_W   = 48;
  localparam int MAX_LENGTH_BYTES = 4;
  localparam int TYPE_BYTES_CAP = 4;
  localparam int OFFSET_WIDTH_DEF = 48;

  localparam int QUEUE_DEPTH    = 4;
  localparam int PTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = PTR_W + 1;

  // Framing mode codes; the unused code behaves as TLV.
  localparam logic [1:0] MODE_LINES  = 2'd0;
  localparam logic [1:0] MODE_LENGTH = 2'd1;
  localparam logic [1:0] MODE_TLV    = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMING_MODE,
    REG_PREFIX_LEN,
    REG_TLV_TYPE,
    REG_TLV_LEN
  } smd_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]       payload_byte;
    logic                    has_byte;
    logic                    message_end;
    logic [OUT_OFFSET_W-1:0] stream_offset;
  } smd_result_t;

  // Up to two results produced by one stream byte, in order.
  typedef struct packed {
    logic [1:0]  count;
    smd_result_t first;
    smd_result_t second;
  } smd_push_t;

  function automatic smd_result_t make_byte(logic [BYTE_W-1:0] b);
    smd_result_t r;
    r.payload_byte  = b;
    r.has_byte      = 1'b1;
    r.message_end   = 1'b0;
    r.stream_offset = '0;
    return r;
  endfunction

  function automatic smd_result_t make_end(logic [OUT_OFFSET_W-1:0] off);
    smd_result_t r;
    r.payload_byte  = '0;
    r.has_byte      = 1'b0;
    r.message_end   = 1'b1;
    r.stream_offset = off;
    return r;
  endfunction

  // Clamp a length-field byte count to 1..MAX_LENGTH_BYTES.
  function automatic logic [CFG_W-1:0] clamp_len(logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (v > CFG_W'(MAX_LENGTH_BYTES)) r = CFG_W'(MAX_LENGTH_BYTES);
    else r = v;
    return r;
  endfunction

  // Cap the TLV type byte count.
  function automatic logic [CFG_W-1:0] cap_type(logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v > CFG_W'(TYPE_BYTES_CAP)) r = CFG_W'(TYPE_BYTES_CAP);
    else r = v;
    return r;
  endfunction

endpackage

// ===== rtl/core/smd_frame.sv =====
// Framing state and per-byte decode: config registers, header/payload tracking,
// carriage-return hold and the saturating byte counter. Depends on smd_pkg.
module smd_frame #(
  parameter int OFFSET_WIDTH = smd_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    accept,
  input  logic [smd_pkg::BYTE_W-1:0]              stream_byte,
  input  logic                                    cfg_write,
  input  logic [smd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [smd_pkg::CFG_W-1:0]               cfg_data,
  output smd_pkg::smd_push_t                      push
);
  import smd_pkg::*;

  localparam logic [OFFSET_WIDTH-1:0] CountMax = '1;

  logic [1:0]              framing_mode;
  logic [CFG_W-1:0]        prefix_length_bytes;
  logic [CFG_W-1:0]        tlv_type_bytes;
  logic [CFG_W-1:0]        tlv_length_bytes;

  logic                    in_header, in_header_next;
  logic [HDR_CNT_W-1:0]    header_count, header_count_next;
  logic [LEN_W-1:0]        length_accumulator, length_accumulator_next;
  logic [LEN_W-1:0]        bytes_remaining, bytes_remaining_next;
  logic                    held_cr, held_cr_next;
  logic [OFFSET_WIDTH-1:0] consumed_count, consumed_count_next;

  logic [63:0]             count_wide;
  smd_result_t             end_res;
  logic [CFG_W-1:0]        type_n, len_n;
  logic [HDR_CNT_W-1:0]    hdr_size, hc_inc;
  logic [LEN_W-1:0]        acc_new, rem_dec;

  assign count_wide = 64'(consumed_count_next);
  assign end_res    = make_end(count_wide[OUT_OFFSET_W-1:0]);

  assign type_n   = (framing_mode == MODE_LENGTH) ? '0 : cap_type(tlv_type_bytes);
  assign len_n    = (framing_mode == MODE_LENGTH) ? clamp_len(prefix_length_bytes)
                                                  : clamp_len(tlv_length_bytes);
  assign hdr_size = HDR_CNT_W'(type_n) + HDR_CNT_W'(len_n);
  assign hc_inc   = (header_count != '1) ? header_count + 1'b1 : header_count;
  assign acc_new  = (header_count >= HDR_CNT_W'(type_n))
                    ? {length_accumulator[LEN_W-BYTE_W-1:0], stream_byte}
                    : length_accumulator;
  assign rem_dec  = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : bytes_remaining;

  always_comb begin
    in_header_next          = in_header;
    header_count_next       = header_count;
    length_accumulator_next = length_accumulator;
    bytes_remaining_next    = bytes_remaining;
    held_cr_next            = held_cr;
    consumed_count_next     = consumed_count;
    push                    = '0;
    if (accept) begin
      if (consumed_count != CountMax) consumed_count_next = consumed_count + 1'b1;
      if (framing_mode == MODE_LINES) begin
        if (stream_byte == CHAR_NEWLINE) begin
          held_cr_next = 1'b0;
          push.count   = 2'd1;
          push.first   = end_res;
        end else if (stream_byte == CHAR_CR) begin
          // a second CR releases the one held
          if (held_cr) begin
            push.count = 2'd1;
            push.first = make_byte(CHAR_CR);
          end
          held_cr_next = 1'b1;
        end else begin
          if (held_cr) begin
            push.count  = 2'd2;
            push.first  = make_byte(CHAR_CR);
            push.second = make_byte(stream_byte);
          end else begin
            push.count = 2'd1;
            push.first = make_byte(stream_byte);
          end
          held_cr_next = 1'b0;
        end
      end else if (in_header) begin
        if (hc_inc >= hdr_size) begin
          bytes_remaining_next    = acc_new;
          length_accumulator_next = '0;
          header_count_next       = '0;
          if (acc_new == '0) begin
            push.count = 2'd1;
            push.first = end_res;
          end else begin
            in_header_next = 1'b0;
          end
        end else begin
          length_accumulator_next = acc_new;
          header_count_next       = hc_inc;
        end
      end else begin
        push.count           = 2'd1;
        push.first           = make_byte(stream_byte);
        bytes_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          in_header_next          = 1'b1;
          header_count_next       = '0;
          length_accumulator_next = '0;
          push.count              = 2'd2;
          push.second             = end_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      framing_mode        <= MODE_LINES;
      prefix_length_bytes <= CFG_W'(2);
      tlv_type_bytes      <= CFG_W'(1);
      tlv_length_bytes    <= CFG_W'(2);
      in_header           <= 1'b1;
      header_count        <= '0;
      length_accumulator  <= '0;
      bytes_remaining     <= '0;
      held_cr             <= 1'b0;
      consumed_count      <= '0;
    end else begin
      in_header          <= in_header_next;
      header_count       <= header_count_next;
      length_accumulator <= length_accumulator_next;
      bytes_remaining    <= bytes_remaining_next;
      held_cr            <= held_cr_next;
      consumed_count     <= consumed_count_next;
      if (cfg_write) begin
        unique case (smd_reg_t'(cfg_index))
          REG_FRAMING_MODE: framing_mode        <= cfg_data[1:0];
          REG_PREFIX_LEN:   prefix_length_bytes <= cfg_data;
          REG_TLV_TYPE:     tlv_type_bytes      <= cfg_data;
          REG_TLV_LEN:      tlv_length_bytes    <= cfg_data;
          default:          framing_mode        <= framing_mode;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // a pair of results always opens with a payload byte
  a_pair_starts_with_byte: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.first.has_byte)
    else $error("smd_frame: result pair does not start with a payload byte");

  // the byte counter moves only on an accepted transaction
  a_count_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (!rst && !accept) |=> $stable(consumed_count))
    else $error("smd_frame: byte counter changed without a transaction");
`endif

endmodule

// ===== rtl/core/smd_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on smd_pkg.
module smd_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  smd_pkg::smd_push_t   push,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smd_pkg::smd_result_t head_res
);
  import smd_pkg::*;

  smd_result_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head, tail;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head_res  = entries[head];
  // room for a full pair of results
  assign space     = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[tail] <= push.first;
    if (push.count == 2'd2) entries[PTR_W'(tail + 1'b1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= PTR_W'(head + PTR_W'(pop));
      tail  <= PTR_W'(tail + PTR_W'(push.count));
      count <= QCNT_W'(count + QCNT_W'(push.count) - QCNT_W'(pop));
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= QCNT_W'(QUEUE_DEPTH - 2))
    else $error("smd_outq: results pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("smd_outq: occupancy beyond depth");
`endif

endmodule

// ===== rtl/core/stream_message_deframer_core.sv =====
// Top level of the stream message deframer: framing decode plus result queue.
// Depends on smd_pkg, smd_frame and smd_outq.
//
// Usage:
//   Input channel (in_valid/in_ready, stream_byte) carries one raw stream byte
//   per transaction. Output channel (out_valid/out_ready) carries one result
//   per transaction: a payload byte (has_byte=1) or an end marker
//   (message_end=1) with the saturating count of consumed bytes in
//   stream_offset. One input byte yields zero, one or two results.
//   Each result is registered into the queue and leaves it in order from its head.
//   Throughput: one byte per cycle while the receiver keeps up; the queue holds
//   four results, and in_ready drops when fewer than two free slots remain.
//   Framing mode 0 splits lines on newline (a CR right before it is dropped),
//   mode 1 reads a big-endian length prefix, mode 2 (and 3) skips type bytes,
//   reads a length and passes the value. Write configuration through
//   cfg_write/cfg_index/cfg_data only while the block is idle.
//   Reset (rst, synchronous) empties the queue, restores register defaults and
//   puts the framer at the start of a header with a zero byte count.
//   When the receiver stalls, results wait in the queue and in_ready falls
//   once the queue is nearly full; nothing is dropped.
module stream_message_deframer_core #(
  parameter int OFFSET_WIDTH = smd_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [smd_pkg::BYTE_W-1:0]        stream_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [smd_pkg::BYTE_W-1:0]        payload_byte,
  output logic                              has_byte,
  output logic                              message_end,
  output logic [smd_pkg::OUT_OFFSET_W-1:0]  stream_offset,
  input  logic                              cfg_write,
  input  logic [smd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smd_pkg::CFG_W-1:0]         cfg_data
);
  import smd_pkg::*;

  smd_push_t   push;
  smd_result_t head_res;
  logic        accept;

  // accept a transaction when in_valid is high and the queue has room for a pair
  assign accept = in_valid && in_ready;

  smd_frame #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (stream_byte),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push)
  );

  smd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_res  (head_res)
  );

  // drive the result fields from the queue head
  assign payload_byte  = head_res.payload_byte;
  assign has_byte      = head_res.has_byte;
  assign message_end   = head_res.message_end;
  assign stream_offset = head_res.stream_offset;

`ifndef SYNTHESIS
  // every result is exactly one of payload byte or end marker
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_byte != message_end))
    else $error("stream_message_deframer_core: malformed result");
`endif

endmodule
